// ===== hdl/scto_pkg.sv =====
package scto_pkg;

    typedef struct packed {
        logic signed [63:0] angle;
        logic [1:0]         mode;
    } scto_in_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } scto_out_t;

    localparam logic [1:0] MODE_SIN = 2'd0;
    localparam logic [1:0] MODE_TAN = 2'd1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_TLOSS = 2'd1;
    localparam logic [1:0] STAT_PLOSS = 2'd2;
    localparam logic [1:0] STAT_POLE  = 2'd3;

    localparam int TLOSS_EXP = 32;
    localparam int PLOSS_EXP = 28;
    localparam int SMALL_EXP = -26;

    // 4/pi to 96 bits and pi/4 in q0.64
    localparam logic [95:0] INV_QTR_PI = 96'hA2F9836E_4E441529_FC2757D2;
    localparam logic [63:0] QTR_PI_Q64 = 64'hC90FDAA22168C235;

    localparam logic [63:0] INT64_MAX = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000000000000000;

    function automatic logic [3:0] term_skip(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd2;
            4'd3:    r = 4'd3;
            4'd4:    r = 4'd4;
            4'd5:    r = 4'd4;
            4'd6:    r = 4'd5;
            4'd7:    r = 4'd5;
            default: r = 4'd6;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] mag_of(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // clamp magnitude to int64 max, then apply sign
    function automatic logic [63:0] with_sign(input logic [63:0] m, input logic neg);
        logic [63:0] c;
        c = m[63] ? INT64_MAX : m;
        return neg ? (64'd0 - c) : c;
    endfunction

    function automatic logic [63:0] by_octant(input logic [2:0] oct,
                                              input logic [63:0] s,
                                              input logic [63:0] c);
        logic [2:0]  o1;
        logic [63:0] v;
        o1 = oct + 3'd1;
        v  = o1[1] ? c : s;
        return oct[2] ? (64'd0 - v) : v;
    endfunction

endpackage

// ===== hdl/sin_cos_tan_octant_polynomial.sv =====
// sequence: angle times 4/pi, then fraction times pi/4; a tiny remainder skips the polynomial,
//   else z = y * y, two horner passes of top steps for cosine and sine and a final product
//   by y; each core product is four limb products on one 32x32 multiplier; tangent adds a
//   restoring division; a total loss angle goes straight to output; hand-over waits on m_ready
// throughput: one request at a time; the next request is taken once the sequencer is idle
// reset: aresetn synchronous active low, clears the sequencer and the result valid
module sin_cos_tan_octant_polynomial
    import scto_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 32,
    parameter int CORE_FRAC_BITS  = 62,
    parameter int POLY_DEGREE     = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  scto_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output scto_out_t m_data
);

    localparam int AF = ANGLE_FRAC_BITS;
    localparam int CF = CORE_FRAC_BITS;

    // rounding constants for core products and for the output conversion
    localparam logic [159:0] CORE_HALF = 160'd1 << (CF - 1);
    localparam int SH_R = (CF >= AF) ? (CF - AF) : 0;
    localparam int SH_L = (AF > CF) ? (AF - CF) : 0;
    localparam logic [63:0] OUT_HALF = (SH_R > 0) ? (64'd1 << (SH_R - 1)) : 64'd0;
    localparam logic [63:0] CORE_ONE = 64'd1 << CF;

    // factorials and taylor coefficients round(2^cf / n!), sign alternating by pairs
    localparam logic [63:0] F2  = 64'd2;
    localparam logic [63:0] F3  = 64'd6;
    localparam logic [63:0] F4  = 64'd24;
    localparam logic [63:0] F5  = 64'd120;
    localparam logic [63:0] F6  = 64'd720;
    localparam logic [63:0] F7  = 64'd5040;
    localparam logic [63:0] F8  = 64'd40320;
    localparam logic [63:0] F9  = 64'd362880;
    localparam logic [63:0] F10 = 64'd3628800;
    localparam logic [63:0] F11 = 64'd39916800;
    localparam logic [63:0] F12 = 64'd479001600;
    localparam logic [63:0] F13 = 64'd6227020800;
    localparam logic [63:0] F14 = 64'd87178291200;
    localparam logic [63:0] F15 = 64'd1307674368000;
    localparam logic [63:0] F16 = 64'd20922789888000;
    localparam logic [63:0] F17 = 64'd355687428096000;

    localparam logic [63:0] C0  = CORE_ONE;
    localparam logic [63:0] C1  = CORE_ONE;
    localparam logic [63:0] C2  = 64'd0 - ((CORE_ONE + F2 / 2) / F2);
    localparam logic [63:0] C3  = 64'd0 - ((CORE_ONE + F3 / 2) / F3);
    localparam logic [63:0] C4  = (CORE_ONE + F4 / 2) / F4;
    localparam logic [63:0] C5  = (CORE_ONE + F5 / 2) / F5;
    localparam logic [63:0] C6  = 64'd0 - ((CORE_ONE + F6 / 2) / F6);
    localparam logic [63:0] C7  = 64'd0 - ((CORE_ONE + F7 / 2) / F7);
    localparam logic [63:0] C8  = (CORE_ONE + F8 / 2) / F8;
    localparam logic [63:0] C9  = (CORE_ONE + F9 / 2) / F9;
    localparam logic [63:0] C10 = 64'd0 - ((CORE_ONE + F10 / 2) / F10);
    localparam logic [63:0] C11 = 64'd0 - ((CORE_ONE + F11 / 2) / F11);
    localparam logic [63:0] C12 = (CORE_ONE + F12 / 2) / F12;
    localparam logic [63:0] C13 = (CORE_ONE + F13 / 2) / F13;
    localparam logic [63:0] C14 = 64'd0 - ((CORE_ONE + F14 / 2) / F14);
    localparam logic [63:0] C15 = 64'd0 - ((CORE_ONE + F15 / 2) / F15);
    localparam logic [63:0] C16 = (CORE_ONE + F16 / 2) / F16;
    localparam logic [63:0] C17 = (CORE_ONE + F17 / 2) / F17;

    localparam logic [63:0] COEF [18] = '{C0, C1, C2, C3, C4, C5, C6, C7, C8, C9,
                                          C10, C11, C12, C13, C14, C15, C16, C17};

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL   = 13'b0000000000010,
        S_OCT   = 13'b0000000000100,
        S_RED   = 13'b0000000001000,
        S_Z     = 13'b0000000010000,
        S_HSTEP = 13'b0000000100000,
        S_HADD  = 13'b0000001000000,
        S_HDONE = 13'b0000010000000,
        S_SFIN  = 13'b0000100000000,
        S_FIN   = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_TDONE = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t       state_reg;
    state_t       ret_reg;

    // shared multiplier: 32x32 limb products accumulated into a 160-bit register
    logic [63:0]  mul_a_reg;
    logic [95:0]  mul_b_reg;
    logic [159:0] acc_reg;
    logic         la_reg;
    logic [1:0]   lb_reg;
    logic [1:0]   lb_last_reg;
    logic         prod_neg_reg;

    logic         neg_reg;
    logic [1:0]   mode_reg;
    logic [1:0]   status_reg;
    logic [2:0]   oct_reg;
    logic [63:0]  y_reg;
    logic [63:0]  z_reg;
    logic [63:0]  hacc_reg;
    logic [63:0]  s_reg;
    logic [63:0]  c_reg;
    logic         odd_reg;
    logic [3:0]   j_reg;
    logic [3:0]   top_reg;

    // divider
    logic [63:0]  rem_reg;
    logic [127:0] nq_reg;
    logic [63:0]  dv_reg;
    logic         tneg_reg;
    logic [6:0]   cnt_reg;

    scto_out_t    res_reg;
    scto_out_t    m_data_reg;
    logic         m_valid_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---- input decode
    logic [63:0] in_mag;
    logic        in_tloss;
    logic        in_ploss;
    always_comb begin
        in_mag   = mag_of(s_data.angle);
        in_tloss = ((in_mag >> AF) >> (TLOSS_EXP - 1)) != 64'd0;
        in_ploss = ((in_mag >> AF) >> (PLOSS_EXP - 1)) != 64'd0;
    end

    // ---- multiplier limb product
    logic [63:0]  limb_prod;
    logic [2:0]   limb_sh;
    logic [159:0] acc_sum;
    always_comb begin
        limb_prod = mul_a_reg[la_reg * 32 +: 32] * mul_b_reg[lb_reg * 32 +: 32];
        limb_sh   = {2'd0, la_reg} + {1'b0, lb_reg};
        acc_sum   = acc_reg + ({96'd0, limb_prod} << (limb_sh * 32));
    end

    // core product result: rounded bits above cf, clamped and signed
    logic [63:0] cm_res;
    assign cm_res = with_sign(acc_reg[CF +: 64], prod_neg_reg);

    // ---- octant and fraction from reduction product
    logic [2:0]  oct_raw;
    logic [63:0] frac_raw;
    logic [2:0]  oct_w;
    logic [63:0] frac_w;
    always_comb begin
        oct_raw  = acc_reg[AF + 95 +: 3];
        frac_raw = acc_reg[AF + 31 +: 64];
        oct_w    = oct_raw;
        frac_w   = frac_raw;
        if (neg_reg) begin
            if (frac_raw != 64'd0) begin
                oct_w  = 3'd0 - oct_raw - 3'd1;
                frac_w = 64'd0 - frac_raw;
            end else begin
                oct_w = 3'd0 - oct_raw;
            end
        end
    end

    // ---- remainder, small test, term count
    logic [63:0] y64_w;
    logic [63:0] y_w;
    logic        small_w;
    logic [3:0]  lz_w;
    logic [3:0]  skip_w;
    logic [3:0]  top_w;
    always_comb begin
        y64_w = acc_reg[127:64];
        if (oct_reg[0]) begin
            y64_w = QTR_PI_Q64 - acc_reg[127:64];
        end
        y_w     = y64_w >> (64 - CF);
        small_w = (y64_w >> (63 + SMALL_EXP)) == 64'd0;
        // leading zeros of the top byte, highest set bit wins
        lz_w    = 4'd8;
        for (int b = 0; b <= 7; b++) begin
            if (y64_w[56 + b]) begin
                lz_w = 4'(7 - b);
            end
        end
        skip_w = term_skip(lz_w);
        top_w  = (4'(POLY_DEGREE) > skip_w) ? (4'(POLY_DEGREE) - skip_w) : 4'd0;
    end

    // ---- final selection
    logic [63:0] sx_w;
    logic [63:0] cx_w;
    logic [63:0] out_m;
    logic [63:0] out_w;
    always_comb begin
        sx_w  = by_octant(oct_reg, s_reg, c_reg);
        cx_w  = by_octant(oct_reg + 3'd2, s_reg, c_reg);
        out_m = (mag_of(sx_w) + OUT_HALF) >> SH_R;
        out_m = out_m << SH_L;
        out_w = with_sign(out_m, sx_w[63]);
    end

    // ---- restoring divider step
    logic [64:0] rem_sh;
    logic        div_ge;
    always_comb begin
        rem_sh = {rem_reg, nq_reg[127]};
        div_ge = rem_sh >= {1'b0, dv_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_OUT the hand-over below decides the valid
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        neg_reg  <= s_data.angle[63];
                        mode_reg <= s_data.mode;
                        if (in_tloss) begin
                            res_reg   <= '{value: 64'sd0, status: STAT_TLOSS};
                            state_reg <= S_OUT;
                        end else begin
                            status_reg  <= in_ploss ? STAT_PLOSS : STAT_OK;
                            // angle times 4/pi
                            mul_a_reg   <= in_mag;
                            mul_b_reg   <= INV_QTR_PI;
                            acc_reg     <= '0;
                            la_reg      <= 1'b0;
                            lb_reg      <= 2'd0;
                            lb_last_reg <= 2'd2;
                            ret_reg     <= S_OCT;
                            state_reg   <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    acc_reg <= acc_sum;
                    if (lb_reg == lb_last_reg) begin
                        lb_reg <= 2'd0;
                        la_reg <= 1'b1;
                        if (la_reg) begin
                            state_reg <= ret_reg;
                        end
                    end else begin
                        lb_reg <= lb_reg + 2'd1;
                    end
                end
                S_OCT: begin
                    oct_reg     <= oct_w + {1'b0, mode_reg[1], 1'b0};
                    // fraction times pi/4, high half kept
                    mul_a_reg   <= frac_w;
                    mul_b_reg   <= {32'd0, QTR_PI_Q64};
                    acc_reg     <= '0;
                    la_reg      <= 1'b0;
                    lb_reg      <= 2'd0;
                    lb_last_reg <= 2'd1;
                    ret_reg     <= S_RED;
                    state_reg   <= S_MUL;
                end
                S_RED: begin
                    y_reg   <= y_w;
                    top_reg <= top_w;
                    if (small_w) begin
                        s_reg     <= y_w;
                        c_reg     <= CORE_ONE;
                        state_reg <= S_FIN;
                    end else begin
                        // z = y * y
                        mul_a_reg    <= y_w;
                        mul_b_reg    <= {32'd0, y_w};
                        acc_reg      <= CORE_HALF;
                        prod_neg_reg <= 1'b0;
                        la_reg       <= 1'b0;
                        lb_reg       <= 2'd0;
                        lb_last_reg  <= 2'd1;
                        ret_reg      <= S_Z;
                        state_reg    <= S_MUL;
                    end
                end
                S_Z: begin
                    z_reg     <= cm_res;
                    odd_reg   <= 1'b0;
                    j_reg     <= top_reg;
                    hacc_reg  <= COEF[{top_reg, 1'b0}];
                    state_reg <= S_HSTEP;
                end
                S_HSTEP: begin
                    if (j_reg == 4'd0) begin
                        state_reg <= S_HDONE;
                    end else begin
                        mul_a_reg    <= mag_of(hacc_reg);
                        mul_b_reg    <= {32'd0, mag_of(z_reg)};
                        acc_reg      <= CORE_HALF;
                        prod_neg_reg <= hacc_reg[63] ^ z_reg[63];
                        la_reg       <= 1'b0;
                        lb_reg       <= 2'd0;
                        lb_last_reg  <= 2'd1;
                        j_reg        <= j_reg - 4'd1;
                        ret_reg      <= S_HADD;
                        state_reg    <= S_MUL;
                    end
                end
                S_HADD: begin
                    hacc_reg  <= cm_res + COEF[{j_reg, odd_reg}];
                    state_reg <= S_HSTEP;
                end
                S_HDONE: begin
                    if (!odd_reg) begin
                        // cosine done, start the sine polynomial
                        c_reg     <= hacc_reg;
                        odd_reg   <= 1'b1;
                        j_reg     <= top_reg;
                        hacc_reg  <= COEF[{top_reg, 1'b1}];
                        state_reg <= S_HSTEP;
                    end else begin
                        mul_a_reg    <= mag_of(y_reg);
                        mul_b_reg    <= {32'd0, mag_of(hacc_reg)};
                        acc_reg      <= CORE_HALF;
                        prod_neg_reg <= y_reg[63] ^ hacc_reg[63];
                        la_reg       <= 1'b0;
                        lb_reg       <= 2'd0;
                        lb_last_reg  <= 2'd1;
                        ret_reg      <= S_SFIN;
                        state_reg    <= S_MUL;
                    end
                end
                S_SFIN: begin
                    s_reg     <= cm_res;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (mode_reg == MODE_TAN) begin
                        if (cx_w == 64'd0) begin
                            res_reg.value  <= ($signed(sx_w) > 64'sd0) ? INT64_MAX : INT64_MIN;
                            res_reg.status <= STAT_POLE;
                            state_reg      <= S_OUT;
                        end else begin
                            rem_reg   <= '0;
                            nq_reg    <= {64'd0, mag_of(sx_w)} << AF;
                            dv_reg    <= mag_of(cx_w);
                            tneg_reg  <= sx_w[63] ^ cx_w[63];
                            cnt_reg   <= '0;
                            state_reg <= S_DIV;
                        end
                    end else begin
                        res_reg.value  <= out_w;
                        res_reg.status <= status_reg;
                        state_reg      <= S_OUT;
                    end
                end
                S_DIV: begin
                    rem_reg <= div_ge ? 64'(rem_sh - {1'b0, dv_reg}) : rem_sh[63:0];
                    nq_reg  <= {nq_reg[126:0], div_ge};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127) begin
                        state_reg <= S_TDONE;
                    end
                end
                S_TDONE: begin
                    if (nq_reg[127:63] != '0) begin
                        res_reg.value <= tneg_reg ? INT64_MIN : INT64_MAX;
                    end else begin
                        res_reg.value <= with_sign(nq_reg[63:0], tneg_reg);
                    end
                    res_reg.status <= status_reg;
                    state_reg      <= S_OUT;
                end
                S_OUT: begin
                    // hand over once the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
